// File: rtl/edd_pkg.sv
// Shared types, constants and fixed-point helpers for the error diffusion dither.
package edd_pkg;

  // Stored error and a wide working word, both signed Q4
  typedef logic signed [15:0] err_t;
  typedef logic signed [19:0] wide_t;

  // Field and register widths
  localparam int GRAY_W     = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // Register reset values and limits
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [IMG_H_W-1:0] MAX_HEIGHT   = 13'd4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Threshold and white level in Q4
  localparam wide_t THRESH_Q4 = 20'sd2032;
  localparam wide_t WHITE_Q4  = 20'sd4080;

  // Diffusion weights in sixteenths
  localparam wide_t W_RIGHT = 20'sd7;
  localparam wide_t W_BELOW = 20'sd5;
  localparam wide_t W_BLEFT = 20'sd3;

  localparam wide_t S16_MAX = 20'sd32767;
  localparam wide_t S16_MIN = -20'sd32768;

  // Clamp a wide value to the 16-bit signed range
  function automatic err_t sat16(input wide_t v);
    err_t r;
    if (v > S16_MAX) begin
      r = 16'sh7FFF;
    end else if (v < S16_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Floored share of an error: floor(e * w / 16)
  function automatic err_t share(input wide_t e, input wide_t w);
    wide_t p;
    p = e * w;
    return sat16(p >>> 4);
  endfunction

endpackage

// File: rtl/edd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module edd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/error_diffusion_dither.sv
// Floyd-Steinberg error diffusion dither for a stream of 8-bit gray pixels.
//
// Usage: pixels of a frame arrive in raster order on the input channel
// (in_valid, in_stall, gray_in). Each pixel yields one item on the output
// channel: is_white, plus row_end on the last pixel of a row and frame_end
// on the last pixel of the frame. Frame size comes from image_width and
// image_height, written through cfg_write/cfg_index/cfg_data between items.
// An item goes from input accept through the compute stage and the output
// register; one pixel is taken every cycle unless the receiver stalls. The
// next-row error store is a single RAM read at input accept and written
// once per pixel; the right-carry loop closes within the compute stage.
// Reset clears counters, carries and the store fill count, so a new frame
// starts at once; no clearing pass is run. Unwritten store entries read as
// zero through the fill count.
// When the receiver stalls, the output register holds its item, the compute
// stage holds one more, and in_stall rises only when both are full.
module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [GRAY_W-1:0]     gray_in,
  // dithered output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_white,
  output logic                  row_end,
  output logic                  frame_end
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  // Configuration registers
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  // Position counters
  logic [CW-1:0]    column_index;
  logic [ROW_W-1:0] row_index;

  // Compute stage
  logic              s1_valid;
  logic [CW-1:0]     s1_col;
  logic [GRAY_W-1:0] s1_gray;
  logic              s1_last_col;
  logic              s1_last_row;
  logic              s1_first_row;

  // Error state
  err_t          right_carry;
  err_t          diag_hold;
  logic          pend_valid;
  logic [CW-1:0] pend_col;
  err_t          pend_val;
  logic          wb_valid;
  logic [CW-1:0] wb_addr;
  err_t          wb_data;
  logic [CW:0]   fill;

  // RAM ports
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  err_t          ram_wdata;
  logic [15:0]   ram_rdata;

  logic in_accept;
  logic s1_fire;

  logic [XW-1:0]      eff_w;
  logic [IMG_H_W-1:0] eff_h;
  logic               last_col;
  logic               last_row;

  err_t  stored_err;
  err_t  down_in;
  err_t  sum;
  wide_t sum_w;
  wide_t err_w;
  logic  white;
  err_t  sh_right;
  err_t  sh_below;
  err_t  sh_bleft;
  err_t  sh_bright;
  err_t  pend_merged;
  logic  [CW:0] col_plus;

  // Handshake: compute stage moves on when the output register frees up
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size and find row and frame ends
  always_comb begin
    eff_w = XW'(image_width);
    if (eff_w > XW'(MAX_WIDTH)) begin
      eff_w = XW'(MAX_WIDTH);
    end
    eff_h = (image_height > MAX_HEIGHT) ? MAX_HEIGHT : image_height;
    last_col = (XW'(column_index) + XW'(1)) >= eff_w;
    last_row = ({1'b0, row_index} + IMG_H_W'(1)) >= eff_h;
  end

  // Advance position and load the compute stage on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        if (last_col) begin
          column_index <= '0;
          row_index    <= last_row ? '0 : row_index + ROW_W'(1);
        end else begin
          column_index <= column_index + CW'(1);
        end
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col       <= column_index;
      s1_gray      <= gray_in;
      s1_last_col  <= last_col;
      s1_last_row  <= last_row;
      s1_first_row <= (row_index == '0);
    end
  end

  // Next-row error store
  edd_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(column_index),
    .rdata(ram_rdata)
  );

  // Pick the stored entry for this column: pending entry, zero past the fill count, last write, or RAM
  always_comb begin
    if (pend_valid && pend_col == s1_col) begin
      stored_err = pend_val;
    end else if ({1'b0, s1_col} >= fill) begin
      stored_err = '0;
    end else if (wb_valid && wb_addr == s1_col) begin
      stored_err = wb_data;
    end else begin
      stored_err = err_t'(ram_rdata);
    end
    // no error enters the first row of a frame
    down_in = s1_first_row ? '0 : stored_err;
  end

  // Quantize and split the error
  always_comb begin
    sum_w     = wide_t'({s1_gray, 4'b0000}) + wide_t'(right_carry) + wide_t'(down_in);
    sum       = sat16(sum_w);
    white     = wide_t'(sum) > THRESH_Q4;
    err_w     = wide_t'(sum) - (white ? WHITE_Q4 : wide_t'(0));
    sh_right  = share(err_w, W_RIGHT);
    sh_below  = share(err_w, W_BELOW);
    sh_bleft  = share(err_w, W_BLEFT);
    sh_bright = sat16(err_w >>> 4);
    if (!s1_last_row && s1_col != '0) begin
      pend_merged = sat16(wide_t'(pend_val) + wide_t'(sh_bleft));
    end else begin
      pend_merged = pend_val;
    end
    col_plus = {1'b0, s1_col} + (CW + 1)'(1);
  end

  // Retire the left neighbor's entry when this item fires
  assign ram_we    = s1_fire && pend_valid;
  assign ram_waddr = pend_col;
  assign ram_wdata = pend_merged;

  // Update carries, pending entry and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      diag_hold   <= '0;
      pend_valid  <= 1'b0;
      wb_valid    <= 1'b0;
      fill        <= '0;
    end else if (s1_fire) begin
      right_carry <= s1_last_col ? '0 : sh_right;
      pend_valid  <= 1'b1;
      if (ram_we) begin
        wb_valid <= 1'b1;
      end
      if (!s1_last_row) begin
        diag_hold <= s1_last_col ? '0 : sh_bright;
        if (col_plus > fill) begin
          fill <= col_plus;
        end
      end else begin
        diag_hold <= '0;
      end
    end
  end

  // Last row keeps the stored entry as it is, so it is written back unchanged
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pend_col <= s1_col;
      if (s1_last_row) begin
        pend_val <= stored_err;
      end else begin
        pend_val <= sat16(wide_t'(sh_below) + wide_t'(diag_hold));
      end
      if (ram_we) begin
        wb_addr <= ram_waddr;
        wb_data <= ram_wdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      is_white  <= white;
      row_end   <= s1_last_col;
      frame_end <= s1_last_col && s1_last_row;
    end
  end

endmodule
